// ===== rtl/core/area_average_downscaler_defines.svh =====
// ----------------------------------------------------------------------------
// area average downscaler assertion macros
// shared assertion forms for the downscaler rtl
// ----------------------------------------------------------------------------
`ifndef AREA_AVERAGE_DOWNSCALER_DEFINES_SVH
`define AREA_AVERAGE_DOWNSCALER_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked assertion, quiet while reset is held
`define AAD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked assertion, checked during reset as well
`define AAD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AAD_ASSERT(label, clk, rst_n, prop, msg)
`define AAD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/core/aad_pkg.sv =====
// ----------------------------------------------------------------------------
// aad_pkg
// types, widths and helpers shared by the area average downscaler
// ----------------------------------------------------------------------------
package aad_pkg;

    localparam int CFG_W    = 13;
    localparam int CNT_W    = 12;
    localparam int SMP_W    = 8;
    localparam int ACC_W    = 32;
    localparam int NUM_LANE = 4;
    localparam int POS_W    = 26;
    localparam int MULB_W   = 13;
    localparam int PROD_W   = POS_W + MULB_W;
    localparam int AREA_W   = 25;
    localparam int NUM_W    = 34;
    localparam int DEN_W    = 26;

    // register indexes
    localparam logic [2:0] REG_SRC_W = 3'd0;
    localparam logic [2:0] REG_SRC_H = 3'd1;
    localparam logic [2:0] REG_DST_W = 3'd2;
    localparam logic [2:0] REG_DST_H = 3'd3;
    localparam logic [2:0] REG_CHANS = 3'd4;

    typedef struct packed {
        logic [SMP_W-1:0] sample_c3;
        logic [SMP_W-1:0] sample_c2;
        logic [SMP_W-1:0] sample_c1;
        logic [SMP_W-1:0] sample_c0;
    } t_sample;

    typedef struct packed {
        logic             frame_end;
        logic [SMP_W-1:0] pixel_c3;
        logic [SMP_W-1:0] pixel_c2;
        logic [SMP_W-1:0] pixel_c1;
        logic [SMP_W-1:0] pixel_c0;
    } t_pixel;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_POS,
        S_OVL,
        S_WT,
        S_RD,
        S_ACC,
        S_WR,
        S_AREA,
        S_DIV,
        S_DONE
    } t_state;

    // length of the overlap of [a0,a1) and [b0,b1)
    function automatic logic [POS_W-1:0] overlap(
        input logic [POS_W-1:0] a0,
        input logic [POS_W-1:0] a1,
        input logic [POS_W-1:0] b0,
        input logic [POS_W-1:0] b1
    );
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a1 < b1) ? a1 : b1;
        return (hi > lo) ? (hi - lo) : '0;
    endfunction

endpackage

// ===== rtl/core/aad_divider.sv =====
// ----------------------------------------------------------------------------
// aad_divider
// restoring divider for one saturated 8-bit quotient, one bit a cycle
// ----------------------------------------------------------------------------
module aad_divider import aad_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [SMP_W-1:0] o_quot
);

    logic             r_busy;
    logic             r_done;
    logic [3:0]       r_k;
    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_dsh;
    logic [SMP_W-1:0] r_q;
    logic             ge;

    assign ge = r_rem >= r_dsh;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= 4'd8;
            end else if (r_busy) begin
                if ((r_k == 4'd8 && ge) || r_k == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k <= r_k - 4'd1;
                end
            end
        end
    end

    // remainder and quotient; the first step only detects saturation
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= {i_den, 8'b0};
            r_q   <= '0;
        end else if (r_busy) begin
            if (r_k == 4'd8) begin
                if (ge) begin
                    r_q <= '1;
                end
            end else if (ge) begin
                r_rem         <= r_rem - r_dsh;
                r_q[r_k[2:0]] <= 1'b1;
            end
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/core/area_average_downscaler.sv =====
// ----------------------------------------------------------------------------
// area_average_downscaler
// area averaging image downscaler on one shared multiplier and a divider
// ----------------------------------------------------------------------------
// source pixels enter on the i_in_valid / o_in_ready channel in raster order,
// one transaction per pixel with four channel bytes. destination pixels leave
// on o_out_valid / i_out_ready, also in raster order, frame_end on the last.
// sizes and channel count are written through i_cfg_we / i_cfg_index /
// i_cfg_data; the user must write them only between frames while the block
// is idle, as the block itself does not enforce it. after reset the
// accumulator memory is cleared one row a cycle, every row of it, before
// o_in_ready first rises. each pixel takes one shared multiplier through
// 4 position products and 4 weight products, and through four
// read-modify-write row passes. a pixel that closes a box adds the area
// product and one divider run for each of the MAX_CHANNELS lanes. the
// result sits in an output register; a stalled receiver holds it there and
// the block stops before the next result until it is taken.
// ----------------------------------------------------------------------------
`include "area_average_downscaler_defines.svh"

module area_average_downscaler import aad_pkg::*; #(
    parameter int MAX_WIDTH    = 4096,
    parameter int MAX_CHANNELS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_sample          i_sample,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_pixel           o_pixel,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ADDR_W = COL_W + 1;
    localparam int ROW_W  = MAX_CHANNELS * ACC_W;
    localparam int LANE_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_src_w, r_src_h, r_dst_w, r_dst_h;
    logic [2:0]       r_chans;
    logic [CFG_W-1:0] sw, sh, dw, dh;
    logic [2:0]       ch;

    logic [CNT_W-1:0] r_src_col, r_src_row, r_dst_col, r_dst_row;
    logic [2:0]       r_step;
    logic [1:0]       r_row;
    logic [LANE_W-1:0] r_lane;
    logic [ADDR_W-1:0] r_clr;

    logic [SMP_W-1:0] r_smp [MAX_CHANNELS];
    logic [SMP_W-1:0] in_lane [NUM_LANE];
    logic [POS_W-1:0] r_a0, r_b0, r_c0, r_d0;
    logic [POS_W-1:0] r_wx0, r_wx1, r_wy0, r_wy1;
    logic [POS_W-1:0] r_w [4];
    logic             r_col_done, r_row_done, r_line_end, r_frame_last, r_emit;
    logic [ACC_W-1:0] r_acc [MAX_CHANNELS];
    logic [ACC_W-1:0] r_sum [MAX_CHANNELS];
    logic [AREA_W-1:0] r_area;
    logic [SMP_W-1:0] r_pix [MAX_CHANNELS];

    logic [POS_W-1:0]  mul_a;
    logic [MULB_W-1:0] mul_b;
    logic [PROD_W-1:0] r_prod;

    logic [ROW_W-1:0]  mem [2*MAX_WIDTH];
    logic [ROW_W-1:0]  r_rdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ROW_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0] row_addr;

    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic [SMP_W-1:0]  div_quot;

    logic             r_out_valid;
    t_pixel           r_out;
    t_pixel           out_next;
    logic             adv;
    logic             acc_last, lane_last;

    // effective sizes after clamping
    always_comb begin
        sw = (r_src_w == '0) ? CFG_W'(1) :
             (r_src_w > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : r_src_w;
        sh = (r_src_h == '0) ? CFG_W'(1) :
             (r_src_h > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : r_src_h;
        dw = (r_dst_w == '0) ? CFG_W'(1) : (r_dst_w > sw) ? sw : r_dst_w;
        dh = (r_dst_h == '0) ? CFG_W'(1) : (r_dst_h > sh) ? sh : r_dst_h;
        ch = (r_chans == '0) ? 3'd1 :
             (r_chans > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : r_chans;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= CFG_W'(1);
            r_src_h <= CFG_W'(1);
            r_dst_w <= CFG_W'(1);
            r_dst_h <= CFG_W'(1);
            r_chans <= 3'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SRC_W: r_src_w <= i_cfg_data;
                REG_SRC_H: r_src_h <= i_cfg_data;
                REG_DST_W: r_dst_w <= i_cfg_data;
                REG_DST_H: r_dst_h <= i_cfg_data;
                REG_CHANS: r_chans <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign in_lane[0] = i_sample.sample_c0;
    assign in_lane[1] = i_sample.sample_c1;
    assign in_lane[2] = i_sample.sample_c2;
    assign in_lane[3] = i_sample.sample_c3;

    assign o_in_ready = (r_state == S_IDLE);
    assign acc_last   = (r_step == 3'(MAX_CHANNELS));
    assign lane_last  = (r_lane == LANE_W'(MAX_CHANNELS - 1));
    assign adv        = !r_emit || !r_out_valid || i_out_ready;

    // row address of the current accumulator pass
    assign row_addr = {r_dst_row[0] ^ r_row[1], r_dst_col[COL_W-1:0] + COL_W'(r_row[0])};

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, memory write and divider start
    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = row_addr;
        mem_wdata = '0;
        div_start = 1'b0;
        for (int l = 0; l < MAX_CHANNELS; l++) begin
            mem_wdata[l*ACC_W +: ACC_W] =
                (r_row == 2'd0 && r_emit && 3'(l) < ch) ? '0 : r_acc[l];
        end
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE: if (i_in_valid) n_state = S_POS;
            S_POS:  if (r_step == 3'd4) n_state = S_OVL;
            S_OVL:  n_state = S_WT;
            S_WT:   if (r_step == 3'd4) n_state = S_RD;
            S_RD:   n_state = S_ACC;
            S_ACC:  if (acc_last) n_state = S_WR;
            S_WR: begin
                mem_we = 1'b1;
                if (r_row == 2'd3) n_state = r_emit ? S_AREA : S_DONE;
                else n_state = S_RD;
            end
            S_AREA: if (r_step == 3'd2) n_state = S_DIV;
            S_DIV: begin
                div_start = (r_step == 3'd0);
                if (r_step != 3'd0 && div_done && lane_last) n_state = S_DONE;
            end
            S_DONE: if (adv) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_POS: begin
                unique case (r_step)
                    3'd0: begin mul_a = POS_W'(r_src_col); mul_b = dw; end
                    3'd1: begin mul_a = POS_W'(r_dst_col); mul_b = sw; end
                    3'd2: begin mul_a = POS_W'(r_src_row); mul_b = dh; end
                    3'd3: begin mul_a = POS_W'(r_dst_row); mul_b = sh; end
                    default: ;
                endcase
            end
            S_WT: begin
                unique case (r_step)
                    3'd0: begin mul_a = r_wx0; mul_b = r_wy0[MULB_W-1:0]; end
                    3'd1: begin mul_a = r_wx1; mul_b = r_wy0[MULB_W-1:0]; end
                    3'd2: begin mul_a = r_wx0; mul_b = r_wy1[MULB_W-1:0]; end
                    3'd3: begin mul_a = r_wx1; mul_b = r_wy1[MULB_W-1:0]; end
                    default: ;
                endcase
            end
            S_ACC: begin
                mul_a = r_w[r_row];
                mul_b = MULB_W'(r_smp[r_step[LANE_W-1:0]]);
            end
            S_AREA: begin
                mul_a = POS_W'(sw);
                mul_b = sh;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // accumulator memory
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rdata <= mem[row_addr];
    end

    // divider operands for the current lane
    assign div_num = NUM_W'({r_sum[r_lane], 1'b0}) + NUM_W'(r_area);
    assign div_den = {r_area, 1'b0};

    aad_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // sequencing counters and frame position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= '0;
            r_row     <= '0;
            r_lane    <= '0;
            r_clr     <= '0;
            r_src_col <= '0;
            r_src_row <= '0;
            r_dst_col <= '0;
            r_dst_row <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + ADDR_W'(1);
                S_IDLE: begin
                    r_step <= '0;
                    r_row  <= '0;
                    r_lane <= '0;
                end
                S_POS, S_WT: r_step <= (r_step == 3'd4) ? 3'd0 : r_step + 3'd1;
                S_RD:  r_step <= '0;
                S_ACC: r_step <= r_step + 3'd1;
                S_WR: begin
                    r_row  <= r_row + 2'd1;
                    r_step <= '0;
                end
                S_AREA: r_step <= (r_step == 3'd2) ? 3'd0 : r_step + 3'd1;
                S_DIV: begin
                    if (r_step == 3'd0) begin
                        r_step <= 3'd1;
                    end else if (div_done) begin
                        r_step <= '0;
                        r_lane <= r_lane + LANE_W'(1);
                    end
                end
                S_DONE: begin
                    if (adv) begin
                        priority if (r_frame_last) begin
                            r_src_col <= '0;
                            r_src_row <= '0;
                            r_dst_col <= '0;
                            r_dst_row <= '0;
                        end else if (r_line_end) begin
                            r_src_col <= '0;
                            r_dst_col <= '0;
                            r_src_row <= r_src_row + CNT_W'(1);
                            if (r_row_done) r_dst_row <= r_dst_row + CNT_W'(1);
                        end else begin
                            r_src_col <= r_src_col + CNT_W'(1);
                            if (r_col_done) r_dst_col <= r_dst_col + CNT_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        logic [POS_W-1:0] a1, b1, b2, c1, d1, d2;
        a1 = r_a0 + POS_W'(dw);
        b1 = r_b0 + POS_W'(sw);
        b2 = b1 + POS_W'(sw);
        c1 = r_c0 + POS_W'(dh);
        d1 = r_d0 + POS_W'(sh);
        d2 = d1 + POS_W'(sh);
        unique case (r_state)
            S_IDLE: begin
                for (int l = 0; l < MAX_CHANNELS; l++) begin
                    r_smp[l] <= (3'(l) < ch) ? in_lane[l] : '0;
                end
            end
            S_POS: begin
                unique case (r_step)
                    3'd1: r_a0 <= r_prod[POS_W-1:0];
                    3'd2: r_b0 <= r_prod[POS_W-1:0];
                    3'd3: r_c0 <= r_prod[POS_W-1:0];
                    3'd4: r_d0 <= r_prod[POS_W-1:0];
                    default: ;
                endcase
            end
            S_OVL: begin
                r_wx0        <= overlap(r_a0, a1, r_b0, b1);
                r_wx1        <= overlap(r_a0, a1, b1, b2);
                r_wy0        <= overlap(r_c0, c1, r_d0, d1);
                r_wy1        <= overlap(r_c0, c1, d1, d2);
                r_col_done   <= a1 >= b1;
                r_row_done   <= c1 >= d1;
                r_emit       <= (a1 >= b1) && (c1 >= d1);
                r_line_end   <= (CFG_W'(r_src_col) + CFG_W'(1)) >= sw;
                r_frame_last <= ((CFG_W'(r_src_col) + CFG_W'(1)) >= sw) &&
                                ((CFG_W'(r_src_row) + CFG_W'(1)) >= sh);
            end
            S_WT: begin
                if (r_step != 3'd0) r_w[r_step[1:0] - 2'd1] <= r_prod[POS_W-1:0];
            end
            S_ACC: begin
                if (r_step == 3'd0) begin
                    for (int l = 0; l < MAX_CHANNELS; l++) begin
                        r_acc[l] <= r_rdata[l*ACC_W +: ACC_W];
                    end
                end else begin
                    r_acc[r_step[LANE_W-1:0] - LANE_W'(1)] <=
                        r_acc[r_step[LANE_W-1:0] - LANE_W'(1)] + r_prod[ACC_W-1:0];
                end
            end
            S_WR: begin
                if (r_row == 2'd0) begin
                    for (int l = 0; l < MAX_CHANNELS; l++) r_sum[l] <= r_acc[l];
                end
            end
            S_AREA: begin
                if (r_step == 3'd1) r_area <= r_prod[AREA_W-1:0];
            end
            S_DIV: begin
                if (r_step != 3'd0 && div_done) begin
                    r_pix[r_lane] <= (3'(r_lane) < ch) ? div_quot : '0;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && r_emit && adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // assembled destination pixel
    always_comb begin
        out_next           = '0;
        out_next.pixel_c0  = r_pix[0];
        if (MAX_CHANNELS > 1) out_next.pixel_c1 = r_pix[1 % MAX_CHANNELS];
        if (MAX_CHANNELS > 2) out_next.pixel_c2 = r_pix[2 % MAX_CHANNELS];
        if (MAX_CHANNELS > 3) out_next.pixel_c3 = r_pix[3 % MAX_CHANNELS];
        out_next.frame_end = r_frame_last;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && r_emit && adv) begin
            r_out <= out_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel     = r_out;

    // checks
    `AAD_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready, "input taken while busy")
    `AAD_ASSERT(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_DONE), "result loaded outside done step")
    `AAD_ASSERT(a_no_accept_clear, i_clk, i_rst_n, (r_state == S_CLEAR) |-> !o_in_ready, "ready during memory clear")

endmodule
